>>> hw/rtl/mseg_pkg.sv
// Shared types, constants and the segment decoder for the seven-segment counter.
package mseg_pkg;

  // The count always spans four decimal places, whatever the display width.
  localparam int unsigned NumDecDigits = 4;
  localparam int unsigned ValueW       = 14;
  localparam logic [ValueW-1:0] TopValue = 14'd9999;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgCountMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScansPerStep = 2'd1;
  localparam logic [7:0] ScansReset = 8'd10;

  typedef enum logic [1:0] {
    MODE_UP     = 2'd0,
    MODE_DOWN   = 2'd1,
    MODE_UPDOWN = 2'd2
  } mode_e;

  // Control that the top level broadcasts to every digit cell.
  typedef struct packed {
    logic load;      // reload the start value
    logic load_max;  // start value is all nines
    logic step;      // the count changes this cycle
    logic down;      // direction of the change
  } cell_ctrl_t;

  // Decimal digit to segments, bit 0 is segment a, 1 means lit.
  function automatic logic [6:0] seg_decode(input logic [3:0] digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

>>> hw/rtl/mseg_digit_cell.sv
// One decimal digit of the counter, passing its carry or borrow to the next place.
module mseg_digit_cell
  import mseg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       carry_i,
  output logic       carry_o,
  output logic [3:0] digit_o,
  output logic       at_max_o,
  output logic       at_min_o
);

  logic [3:0] digit_q, digit_d;

  assign at_max_o = (digit_q == 4'd9);
  assign at_min_o = (digit_q == 4'd0);
  assign digit_o  = digit_q;

  // The neighbour moves only when this digit wraps.
  assign carry_o = carry_i && (ctrl_i.down ? at_min_o : at_max_o);

  // Next digit: reload, or count by one when the lower places wrap.
  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.load) begin
      digit_d = ctrl_i.load_max ? 4'd9 : 4'd0;
    end else if (ctrl_i.step && carry_i) begin
      if (ctrl_i.down) begin
        digit_d = at_min_o ? 4'd9 : digit_q - 4'd1;
      end else begin
        digit_d = at_max_o ? 4'd0 : digit_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

>>> hw/rtl/multiplexed_4digit_7seg_counter.sv
// Top level of the multiplexed seven-segment decimal counter.
//
// Usage: each transaction on the input channel carries one tick bit. For every
// input transaction the block returns one output transaction that describes
// the digit slot current before that tick: the active-low digit enables, the
// segment pattern of the matching decimal digit and the count being shown.
// A tick of one advances the scan by one slot; a tick of zero only repeats
// the current slot. After scans_per_step full scans the count steps in the
// configured mode (up, down or ping-pong between 0 and 9999).
// The result sits in an output register from the cycle after the input
// transaction. One input transaction is taken every cycle; the rate is set
// by the single output register, which accepts a new transaction in the
// same cycle that its held result is taken. If the receiver stalls, the
// held result stays put and the input channel is held off until it drains.
// The count lives in a row of four decimal digit cells joined by a carry
// chain. At reset the count is 0, the mode is up and scans_per_step is 10.
// The configuration port is always ready; writing count_mode reloads the
// start value and restarts the scan.
module multiplexed_4digit_7seg_counter
  import mseg_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                tick_i,
  // Output channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          digit_select_o,
  output logic [6:0]          segments_o,
  output logic [ValueW-1:0]   shown_value_o
);

  localparam int unsigned PosW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(DIGIT_COUNT - 1);

  // Configuration registers and control state.
  mode_e           mode_q;
  logic [7:0]      scans_q;
  logic [PosW-1:0] scan_pos_q, scan_pos_d;
  logic [7:0]      repeats_q, repeats_d;
  logic            going_down_q, going_down_d;

  // Output register.
  logic              out_valid_q;
  logic [3:0]        sel_q, sel_d;
  logic [6:0]        seg_q;
  logic [ValueW-1:0] value_q;

  logic cfg_wr, mode_wr, scans_wr, in_acc, tick_acc;
  logic last_slot, step_now, change, at_top, at_bot, dir_down;
  logic [7:0] limit, repeats_inc;
  logic [3:0] cur_digit;
  logic [ValueW-1:0] count_bin;
  cell_ctrl_t cell_ctrl;

  logic [3:0] digits   [NumDecDigits];
  logic       cell_max [NumDecDigits];
  logic       cell_min [NumDecDigits];
  logic       carry    [NumDecDigits+1];

  // Handshakes.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign mode_wr     = cfg_wr && (cfg_index_i == CfgCountMode);
  assign scans_wr    = cfg_wr && (cfg_index_i == CfgScansPerStep);
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign tick_acc    = in_acc && tick_i;

  // Scan bookkeeping: decide when the count steps.
  assign last_slot   = (scan_pos_q == LastPos);
  assign repeats_inc = repeats_q + 8'd1;
  assign limit       = (scans_q == 8'd0) ? 8'd1 : scans_q;
  assign step_now    = tick_acc && last_slot && (repeats_inc >= limit);

  always_comb begin
    scan_pos_d = scan_pos_q;
    repeats_d  = repeats_q;
    if (mode_wr) begin
      scan_pos_d = '0;
      repeats_d  = '0;
    end else if (tick_acc) begin
      if (last_slot) begin
        scan_pos_d = '0;
        repeats_d  = step_now ? 8'd0 : repeats_inc;
      end else begin
        scan_pos_d = scan_pos_q + PosW'(1);
      end
    end
  end

  // Stepping rule, including the pause at each end in ping-pong mode.
  always_comb begin
    at_top = 1'b1;
    at_bot = 1'b1;
    for (int i = 0; i < NumDecDigits; i++) begin
      at_top = at_top && cell_max[i];
      at_bot = at_bot && cell_min[i];
    end
  end

  always_comb begin
    dir_down     = (mode_q == MODE_DOWN) || ((mode_q == MODE_UPDOWN) && going_down_q);
    change       = step_now;
    going_down_d = going_down_q;
    if (mode_wr) begin
      going_down_d = 1'b0;
    end else if (step_now && (mode_q == MODE_UPDOWN)) begin
      if (!going_down_q && at_top) begin
        going_down_d = 1'b1;
        change       = 1'b0;
      end else if (going_down_q && at_bot) begin
        going_down_d = 1'b0;
        change       = 1'b0;
      end
    end
  end

  assign cell_ctrl.load     = mode_wr;
  assign cell_ctrl.load_max = (cfg_data_i[1:0] == MODE_DOWN);
  assign cell_ctrl.step     = change;
  assign cell_ctrl.down     = dir_down;

  // Row of digit cells, units first.
  assign carry[0] = 1'b1;
  for (genvar g = 0; g < NumDecDigits; g++) begin : g_cell
    mseg_digit_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .carry_i  (carry[g]),
      .carry_o  (carry[g+1]),
      .digit_o  (digits[g]),
      .at_max_o (cell_max[g]),
      .at_min_o (cell_min[g])
    );
  end

  // Digit for the current slot; places beyond the count show zero.
  always_comb begin
    cur_digit = 4'd0;
    for (int i = 0; i < NumDecDigits; i++) begin
      if (int'(scan_pos_q) == i) begin
        cur_digit = digits[i];
      end
    end
  end

  // Enable of the current position, active low; out-of-range positions stay off.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sel_d[i] = !(int'(scan_pos_q) == (int'(DIGIT_COUNT) - 1 - i));
    end
  end

  // Binary value of the count from its decimal places.
  assign count_bin = ValueW'({10'd0, digits[3]} * 14'd1000)
                   + ValueW'({10'd0, digits[2]} * 14'd100)
                   + ValueW'({10'd0, digits[1]} * 14'd10)
                   + {10'd0, digits[0]};

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_UP;
      scans_q      <= ScansReset;
      scan_pos_q   <= '0;
      repeats_q    <= '0;
      going_down_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (mode_wr) begin
        mode_q <= (cfg_data_i[1:0] == MODE_DOWN)   ? MODE_DOWN :
                  (cfg_data_i[1:0] == MODE_UPDOWN) ? MODE_UPDOWN : MODE_UP;
      end
      if (scans_wr) begin
        scans_q <= cfg_data_i;
      end
      scan_pos_q   <= scan_pos_d;
      repeats_q    <= repeats_d;
      going_down_q <= going_down_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload, loaded with each accepted transaction.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sel_q   <= sel_d;
      seg_q   <= seg_decode(cur_digit);
      value_q <= count_bin;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign digit_select_o = sel_q;
  assign segments_o     = seg_q;
  assign shown_value_o  = value_q;

  // The shown count never leaves its decimal range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (shown_value_o <= TopValue))
    else $error("shown value beyond 9999");

  // At most one digit is enabled at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(~digit_select_o) <= 1))
    else $error("more than one digit enabled");

  // Writing down mode reloads all nines and restarts the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_wr && (cfg_data_i[1:0] == MODE_DOWN)) |=>
      ((count_bin == TopValue) && (scan_pos_q == '0) && (repeats_q == 8'd0)))
    else $error("down mode reload failed");

  // The scan only moves on an accepted tick or a mode write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!tick_acc && !mode_wr) |=> $stable(scan_pos_q))
    else $error("scan position moved without a tick");

  // The count only changes at the end of a scan or on a reload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!step_now && !mode_wr) |=> $stable(count_bin))
    else $error("count changed mid scan");

endmodule

>>> tb/multiplexed_4digit_7seg_counter_tb.sv
// Self-checking testbench for the multiplexed four-digit seven-segment decimal counter.
`timescale 1ns / 100ps

module multiplexed_4digit_7seg_counter_tb
  import mseg_pkg::*;
();

  localparam int unsigned DigitCount  = 4;
  localparam int unsigned CycleLimit  = 100_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxShown    = 40;

  // Indexes that decode to no register; writes to them must leave the block alone.
  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 2'd3;

  // One display slot as the block presents it.
  typedef struct packed {
    logic [3:0]        digit_select;
    logic [6:0]        segments;
    logic [ValueW-1:0] shown_value;
  } slot_t;

  // Tracks the scan and the count, and holds the slots still to be shown.
  class scan_tracker;
    logic [1:0]        mode;
    logic [7:0]        scans;
    logic [ValueW-1:0] count;
    int unsigned       position;
    logic [7:0]        repeats;
    logic              going_down;
    logic [6:0]        seg_lut [10];
    slot_t             slots_due[$];
    int unsigned       mismatches;
    int unsigned       results;

    function new();
      seg_lut = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
      mode = MODE_UP;
      scans = ScansReset;
      mismatches = 0;
      results = 0;
      reload();
    endfunction

    // Start value and a fresh scan, as after reset or a mode write.
    function void reload();
      count = (mode == MODE_DOWN) ? TopValue : '0;
      going_down = 1'b0;
      position = 0;
      repeats = '0;
    endfunction

    function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
      if (idx == CfgCountMode) begin
        mode = data[1:0];
        reload();
      end else if (idx == CfgScansPerStep) begin
        scans = data;
      end
    endfunction

    // Moves the count one step; mode three falls through to counting up.
    function void advance_count();
      if (mode == MODE_DOWN) begin
        count = (count == '0) ? TopValue : count - 1'b1;
      end else if (mode == MODE_UPDOWN) begin
        if (!going_down) begin
          if (count >= TopValue) going_down = 1'b1;
          else count = count + 1'b1;
        end else begin
          if (count == '0) going_down = 1'b0;
          else count = count - 1'b1;
        end
      end else begin
        count = (count >= TopValue) ? '0 : count + 1'b1;
      end
    endfunction

    // Works out the slot shown for this transaction, then applies the tick.
    function void note_tick(input logic tick);
      slot_t       s;
      int unsigned v;
      int          pos_bit;
      int unsigned limit;
      v = count;
      for (int unsigned p = 0; p < position; p++) v = v / 10;
      v = v % 10;
      pos_bit = DigitCount - 1 - position;
      if (pos_bit >= 0 && pos_bit < 4) s.digit_select = ~(4'b0001 << pos_bit);
      else s.digit_select = 4'hF;
      s.segments = seg_lut[v];
      s.shown_value = count;
      slots_due.push_back(s);

      if (tick) begin
        position++;
        if (position >= DigitCount) begin
          position = 0;
          repeats = repeats + 1'b1;
          limit = (scans == 0) ? 1 : scans;
          if (repeats >= limit) begin
            repeats = '0;
            advance_count();
          end
        end
      end
    endfunction

    task report(input string msg);
      mismatches++;
      if (mismatches <= MaxShown) $display("MISMATCH %s", msg);
      if (mismatches == MaxShown) $display("Further mismatch lines suppressed.");
    endtask

    task check_slot(input logic [3:0] sel, input logic [6:0] seg,
                    input logic [ValueW-1:0] value);
      slot_t want;
      if (slots_due.size() == 0) begin
        report($sformatf("unexpected result sel=%h seg=%h value=%0d", sel, seg, value));
        return;
      end
      want = slots_due.pop_front();
      results++;
      if (sel !== want.digit_select || seg !== want.segments ||
          value !== want.shown_value) begin
        report($sformatf("result %0d: sel %h/%h seg %h/%h value %0d/%0d (got/want)",
                         results, sel, want.digit_select, seg, want.segments,
                         value, want.shown_value));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                tick_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [3:0]          digit_select_o;
  logic [6:0]          segments_o;
  logic [ValueW-1:0]   shown_value_o;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycles;

  scan_tracker tracker = new();

  multiplexed_4digit_7seg_counter #(
    .DIGIT_COUNT(DigitCount)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .tick_i        (tick_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digit_select_o(digit_select_o),
    .segments_o    (segments_o),
    .shown_value_o (shown_value_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watch every channel at the rising edge and keep the tracker in step.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) tracker.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) tracker.note_tick(tick_i);
      if (out_valid_o && out_ready_i) tracker.check_slot(digit_select_o, segments_o,
                                                         shown_value_o);
    end
  end

  // The receiver stalls at random at the rate of the current phase.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one tick transaction, with random idle cycles ahead of it.
  task automatic send_tick(input logic tick);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    tick_i = tick;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Stops offering ticks and waits for every outstanding slot to arrive.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (tracker.slots_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_ticks(input logic tick, input int unsigned n);
    repeat (n) send_tick(tick);
  endtask

  // Picks a new setting: mode, scan length, both, or an unused index then scan length.
  task automatic random_config();
    int unsigned choice;
    int unsigned pick;
    logic [7:0]  scans_data;
    choice = $urandom_range(3);
    pick = $urandom_range(9);
    if (pick == 0) scans_data = 8'd0;
    else if (pick == 1) scans_data = 8'd255;
    else if (pick == 2) scans_data = 8'($urandom_range(255));
    else scans_data = 8'($urandom_range(1, 3));
    case (choice)
      0: begin
        write_reg(CfgCountMode, CfgDataW'($urandom_range(255)));
      end
      1: begin
        write_reg(CfgScansPerStep, scans_data);
      end
      2: begin
        write_reg(CfgScansPerStep, scans_data);
        write_reg(CfgCountMode, CfgDataW'($urandom_range(255)));
      end
      default: begin
        write_reg($urandom_range(1) ? CfgUnusedLo : CfgUnusedHi,
                  CfgDataW'($urandom_range(255)));
        write_reg(CfgScansPerStep, scans_data);
      end
    endcase
  endtask

  task automatic random_chunk(input int unsigned n);
    repeat (n) send_tick($urandom_range(99) < 80);
  endtask

  // Main stimulus sequence.
  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgCountMode;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    tick_i = 1'b0;
    out_ready_i = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    cycles = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset state, a held slot and the first moves of the scan.
    send_tick(1'b0);
    send_ticks(1'b1, 2);

    // Unused indexes, zero scans and mode three with upper data bits set.
    wait_idle();
    write_reg(CfgUnusedLo, 8'hA5);
    write_reg(CfgUnusedHi, 8'h5A);
    write_reg(CfgScansPerStep, 8'd0);
    write_reg(CfgCountMode, 8'hFF);
    send_ticks(1'b1, 4);
    send_tick(1'b0);
    send_tick(1'b1);

    // Down mode starts from all nines.
    wait_idle();
    write_reg(CfgCountMode, CfgDataW'(MODE_DOWN));
    send_ticks(1'b1, 5);

    // Scan length lowered below the scans already shown.
    wait_idle();
    write_reg(CfgScansPerStep, 8'd3);
    write_reg(CfgCountMode, CfgDataW'(MODE_UPDOWN));
    send_ticks(1'b1, 8);
    wait_idle();
    write_reg(CfgScansPerStep, 8'd1);
    send_ticks(1'b1, 4);

    // Random phases with different idling on each side.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      repeat (4) begin
        wait_idle();
        random_config();
        random_chunk($urandom_range(18, 34));
      end
    end

    // Drain and let the block settle.
    wait_idle();
    repeat (DrainCycles) @(negedge clk_i);

    $display("Checked %0d display slots for digit enables, segments and shown count.",
             tracker.results);
    $display("Covered all count modes, scan lengths from zero to 255 and four idling mixes.");
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/mseg_pkg.sv
hw/rtl/mseg_digit_cell.sv
hw/rtl/multiplexed_4digit_7seg_counter.sv
tb/multiplexed_4digit_7seg_counter_tb.sv
